/* rtl/ctpt_pkg.sv */
// ----------------------------------------------------------------------------
// Clock pulse tempo tracker package
// Shared types, constants, the PPQ tables and the control program.
// ----------------------------------------------------------------------------
package ctpt_pkg;

  // Smallest pulse spacing in microseconds that still yields a tempo.
  localparam int unsigned MIN_DELTA_US = 200;

  // Field widths of the channels.
  localparam int unsigned TS_W      = 32;
  localparam int unsigned BPM_W     = 16;
  localparam int unsigned SPACING_W = 6;
  localparam int unsigned NUM_W     = TS_W + 1;
  localparam int unsigned BASE_W    = 27;
  localparam int unsigned CNT_W     = 6;

  // Register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_PPQ    = 1'b0;
  localparam logic        REG_SYNC   = 1'b1;

  // Register reset values.
  localparam logic [2:0] PPQ_RESET  = 3'd1;
  localparam logic [1:0] SYNC_RESET = 2'd0;

  // Sync source codes that accept pulse events.
  localparam logic [1:0] SYNC_PULSE = 2'd1;
  localparam logic [1:0] SYNC_AUTO  = 2'd2;

  // Event kinds.
  localparam logic CMD_CLOCK = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Datapath operations of one control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_PULSE,
    OP_DIV,
    OP_BPM,
    OP_EMIT,
    OP_CLR
  } op_t;

  // Jump conditions of one control word.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_NO_SYNC,
    C_RST,
    C_NO_TEMPO,
    C_SHORT,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_t;

  localparam int unsigned UC_DEPTH = 10;
  localparam int unsigned PC_W     = $clog2(UC_DEPTH);

  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the program.
  localparam pc_t S_FETCH = PC_W'(0);
  localparam pc_t S_SYNC  = PC_W'(1);
  localparam pc_t S_CMD   = PC_W'(2);
  localparam pc_t S_PULSE = PC_W'(3);
  localparam pc_t S_GAP   = PC_W'(4);
  localparam pc_t S_DIV   = PC_W'(5);
  localparam pc_t S_BPM   = PC_W'(6);
  localparam pc_t S_EMIT  = PC_W'(7);
  localparam pc_t S_HOLD  = PC_W'(8);
  localparam pc_t S_RSTEV = PC_W'(9);

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic sync_ok;
    logic is_rst;
    logic have_tempo;
    logic short_gap;
    logic div_busy;
    logic out_free;
  } status_t;

  // The control program, one word per step.
  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
    case (pc)
      S_FETCH: w = '{op: OP_LATCH, cond: C_NO_IN,    target: S_FETCH};
      S_SYNC:  w = '{op: OP_NOP,   cond: C_NO_SYNC,  target: S_EMIT};
      S_CMD:   w = '{op: OP_NOP,   cond: C_RST,      target: S_RSTEV};
      S_PULSE: w = '{op: OP_PULSE, cond: C_NO_TEMPO, target: S_EMIT};
      S_GAP:   w = '{op: OP_NOP,   cond: C_SHORT,    target: S_EMIT};
      S_DIV:   w = '{op: OP_DIV,   cond: C_DIV_BUSY, target: S_DIV};
      S_BPM:   w = '{op: OP_BPM,   cond: C_NEXT,     target: S_EMIT};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE, target: S_FETCH};
      S_HOLD:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_EMIT};
      S_RSTEV: w = '{op: OP_CLR,   cond: C_ALWAYS,   target: S_EMIT};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_FETCH};
    endcase
    return w;
  endfunction

  // Native 32-PPQ substeps per external pulse.
  function automatic logic [SPACING_W-1:0] spacing_of(input logic [2:0] sel);
    logic [SPACING_W-1:0] s;
    case (sel)
      3'd0:    s = SPACING_W'(32);
      3'd1:    s = SPACING_W'(8);
      3'd2:    s = SPACING_W'(4);
      3'd3:    s = SPACING_W'(2);
      3'd4:    s = SPACING_W'(1);
      default: s = SPACING_W'(8);
    endcase
    return s;
  endfunction

  // Twice the rounding numerator base: 3750000 times the spacing.
  function automatic logic [BASE_W-1:0] num_base(input logic [2:0] sel);
    logic [BASE_W-1:0] b;
    case (sel)
      3'd0:    b = BASE_W'(120000000);
      3'd1:    b = BASE_W'(30000000);
      3'd2:    b = BASE_W'(15000000);
      3'd3:    b = BASE_W'(7500000);
      3'd4:    b = BASE_W'(3750000);
      default: b = BASE_W'(30000000);
    endcase
    return b;
  endfunction

endpackage

/* rtl/ctpt_seq.sv */
// ----------------------------------------------------------------------------
// Clock pulse tempo tracker sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module ctpt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ctpt_pkg::status_t status,
  output ctpt_pkg::ctrl_t   ctrl
);

  ctpt_pkg::pc_t pc_r;
  ctpt_pkg::pc_t pc_nxt;
  logic          take;

  // Current control word.
  assign ctrl = ctpt_pkg::ucode_rom(pc_r);

  // Jump condition of the current word.
  always_comb begin
    case (ctrl.cond)
      ctpt_pkg::C_NEXT:     take = 1'b0;
      ctpt_pkg::C_ALWAYS:   take = 1'b1;
      ctpt_pkg::C_NO_IN:    take = !status.in_valid;
      ctpt_pkg::C_NO_SYNC:  take = !status.sync_ok;
      ctpt_pkg::C_RST:      take = status.is_rst;
      ctpt_pkg::C_NO_TEMPO: take = !status.have_tempo;
      ctpt_pkg::C_SHORT:    take = status.short_gap;
      ctpt_pkg::C_DIV_BUSY: take = status.div_busy;
      ctpt_pkg::C_OUT_FREE: take = status.out_free;
      default:              take = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + ctpt_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ctpt_pkg::S_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* rtl/ctpt_div.sv */
// ----------------------------------------------------------------------------
// Clock pulse tempo tracker divider
// Restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module ctpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  logic [ctpt_pkg::NUM_W-1:0]    dividend,
  input  logic [ctpt_pkg::TS_W-1:0]     divisor,
  output logic [ctpt_pkg::NUM_W-1:0]    quotient,
  output logic                          busy
);

  logic [ctpt_pkg::TS_W-1:0]  rem_r;
  logic [ctpt_pkg::TS_W-1:0]  rem_nxt;
  logic [ctpt_pkg::NUM_W-1:0] q_r;
  logic [ctpt_pkg::CNT_W-1:0] cnt_r;
  logic [ctpt_pkg::TS_W:0]    shifted;
  logic                       ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_r, q_r[ctpt_pkg::NUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor};

  always_comb begin
    if (ge) begin
      rem_nxt = ctpt_pkg::TS_W'(shifted - {1'b0, divisor});
    end else begin
      rem_nxt = shifted[ctpt_pkg::TS_W-1:0];
    end
  end

  assign quotient = q_r;
  assign busy     = cnt_r != '0;

  // Quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[ctpt_pkg::NUM_W-2:0], ge};
    end
  end

  // Steps left after the current one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= ctpt_pkg::CNT_W'(ctpt_pkg::NUM_W - 1);
    end else if (step && busy) begin
      cnt_r <= cnt_r - ctpt_pkg::CNT_W'(1);
    end
  end

endmodule

/* rtl/clock_pulse_tempo_tracker.sv */
// ----------------------------------------------------------------------------
// Clock pulse tempo tracker
// Tempo estimation from timestamped clock and reset jack events.
// ----------------------------------------------------------------------------
// Each event transfer on the input stream gives exactly one result transfer.
// The block works on one event at a time: an ignored event goes straight to
// the emit step, a reset pulse clears the tempo reference, the first clock
// pulse after a reset sets it, one too close to the previous gives no tempo,
// and one that yields a tempo runs the 33 steps of the bit-serial divider that
// forms 1875000*spacing/delta with rounding. A held result waits in the output
// register and stalls the sequencer at its emit step only. Configuration is
// written over the APB port; writing the PPQ select drops the tempo reference.
// ----------------------------------------------------------------------------
module clock_pulse_tempo_tracker #(
  parameter int unsigned MIN_DELTA_US = ctpt_pkg::MIN_DELTA_US
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Event stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [39:0]                      in_tdata,  // timestamp_us[31:0], seq_running[32]
  input  logic                             in_tuser,  // command
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // activity[0], activity_time[32:1], bpm_valid[33], bpm[49:34], master_step[50],
  // step_spacing[56:51], restart[57]
  output logic [63:0]                      out_tdata,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ctpt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  ctpt_pkg::ctrl_t   ctrl;
  ctpt_pkg::status_t status;

  logic [2:0] ppq_r;
  logic [1:0] sync_r;
  logic       cfg_wr;
  logic       reg_sel;

  logic                          cmd_r;
  logic [ctpt_pkg::TS_W-1:0]     ts_r;
  logic                          run_r;
  logic                          have_tempo_r;
  logic [ctpt_pkg::TS_W-1:0]     last_r;
  logic [ctpt_pkg::TS_W-1:0]     delta_r;
  logic [ctpt_pkg::TS_W-1:0]     delta;
  logic                          bvalid_r;
  logic [ctpt_pkg::BPM_W-1:0]    bpm_r;
  logic [ctpt_pkg::NUM_W-1:0]    num;
  logic [ctpt_pkg::NUM_W-1:0]    quot;
  logic [ctpt_pkg::TS_W-1:0]     half;
  logic                          div_busy;
  logic                          sync_ok;
  logic                          latch;
  logic                          out_free;
  logic [ctpt_pkg::SPACING_W-1:0] spacing;

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    case (reg_sel)
      ctpt_pkg::REG_PPQ:  cfg_prdata = {29'd0, ppq_r};
      ctpt_pkg::REG_SYNC: cfg_prdata = {30'd0, sync_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppq_r  <= ctpt_pkg::PPQ_RESET;
      sync_r <= ctpt_pkg::SYNC_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == ctpt_pkg::REG_PPQ) begin
        ppq_r <= cfg_pwdata[2:0];
      end else begin
        sync_r <= cfg_pwdata[1:0];
      end
    end
  end

  // Derived values of the configuration and the pending event.
  assign spacing = ctpt_pkg::spacing_of(ppq_r);
  assign sync_ok = (sync_r == ctpt_pkg::SYNC_PULSE) || (sync_r == ctpt_pkg::SYNC_AUTO);
  assign delta   = ts_r - last_r;
  assign num     = ctpt_pkg::NUM_W'(ctpt_pkg::num_base(ppq_r)) + ctpt_pkg::NUM_W'(delta);
  assign half    = quot[ctpt_pkg::NUM_W-1:1];

  // Sequencer and its condition inputs.
  assign in_tready = ctrl.op == ctpt_pkg::OP_LATCH;
  assign latch     = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    status.in_valid   = in_tvalid;
    status.sync_ok    = sync_ok;
    status.is_rst     = cmd_r == ctpt_pkg::CMD_RESET;
    status.have_tempo = have_tempo_r;
    status.short_gap  = delta_r < ctpt_pkg::TS_W'(MIN_DELTA_US);
    status.div_busy   = div_busy;
    status.out_free   = out_free;
  end

  ctpt_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ctpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.op == ctpt_pkg::OP_PULSE),
    .step     (ctrl.op == ctpt_pkg::OP_DIV),
    .dividend (num),
    .divisor  (delta_r),
    .quotient (quot),
    .busy     (div_busy)
  );

  // Event capture.
  always_ff @(posedge clk) begin
    if (latch) begin
      cmd_r <= in_tuser;
      ts_r  <= in_tdata[31:0];
      run_r <= in_tdata[32];
    end
  end

  // Pulse spacing and clamped tempo.
  always_ff @(posedge clk) begin
    if (ctrl.op == ctpt_pkg::OP_PULSE) begin
      delta_r <= delta;
    end
    if (ctrl.op == ctpt_pkg::OP_BPM) begin
      if (half == '0) begin
        bpm_r <= ctpt_pkg::BPM_W'(1);
      end else if (half > ctpt_pkg::TS_W'(16'hFFFF)) begin
        bpm_r <= '1;
      end else begin
        bpm_r <= half[ctpt_pkg::BPM_W-1:0];
      end
    end
  end

  // Tempo reference state and the new-tempo flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_tempo_r <= 1'b0;
      last_r       <= '0;
      bvalid_r     <= 1'b0;
    end else begin
      if (latch) begin
        bvalid_r <= 1'b0;
      end else if (ctrl.op == ctpt_pkg::OP_BPM) begin
        bvalid_r <= 1'b1;
      end
      if (ctrl.op == ctpt_pkg::OP_PULSE) begin
        last_r <= ts_r;
      end
      if (cfg_wr && reg_sel == ctpt_pkg::REG_PPQ) begin
        have_tempo_r <= 1'b0;
      end else if (ctrl.op == ctpt_pkg::OP_PULSE) begin
        have_tempo_r <= 1'b1;
      end else if (ctrl.op == ctpt_pkg::OP_CLR) begin
        have_tempo_r <= 1'b0;
      end
    end
  end

  // Output register: a result is loaded at the emit step once the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.op == ctpt_pkg::OP_EMIT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ctpt_pkg::OP_EMIT && out_free) begin
      out_tdata_r <= {6'd0,
                      sync_ok && cmd_r == ctpt_pkg::CMD_RESET,
                      spacing,
                      sync_ok && cmd_r == ctpt_pkg::CMD_CLOCK && run_r,
                      (sync_ok && bvalid_r) ? bpm_r : ctpt_pkg::BPM_W'(0),
                      sync_ok && bvalid_r,
                      sync_ok ? ts_r : ctpt_pkg::TS_W'(0),
                      sync_ok};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
